FILE: src/refcounted_register_allocator_macros.svh
// Assertion helpers shared by the allocator RTL.
`ifndef REFCOUNTED_REGISTER_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_REGISTER_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rra_pkg.sv
package rra_pkg;

    localparam int NUM_REGS   = 16;
    localparam int COUNT_BITS = 8;
    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int SCAN_W     = $clog2(NUM_REGS + 1);
    localparam int WIDTH_W    = 7;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_CNT_W  = 8;

    localparam logic [WIDTH_W-1:0]    ARCH_WIDTH_RST = 7'd64;
    localparam logic [COUNT_BITS-1:0] CNT_MAX        = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        OP_DEFINE        = 3'd0,
        OP_RESERVE       = 3'd1,
        OP_RESERVE_IDX   = 3'd2,
        OP_RESERVE_WIDTH = 3'd3,
        OP_FREE          = 3'd4,
        OP_QUERY         = 3'd5,
        OP_TAKE_WIDTH    = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NONE      = 2'd1,
        STAT_FREE_ZERO = 2'd2,
        STAT_SAT       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_FETCH,
        ST_APPLY,
        ST_FAIL
    } state_t;

    // One table entry as seen on the read port.
    typedef struct packed {
        logic                  valid;
        logic [WIDTH_W-1:0]    width;
        logic                  res;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    // Table write request.
    typedef struct packed {
        logic                  en;
        logic                  define;
        logic [IDX_W-1:0]      addr;
        logic [WIDTH_W-1:0]    width;
        logic                  res;
        logic [COUNT_BITS-1:0] count;
    } tbl_wr_t;

    // Scan control from the sequencer.
    typedef struct packed {
        logic               clear;
        logic               sample;
        logic [IDX_W-1:0]   idx;
        logic [WIDTH_W-1:0] key;
    } scan_ctl_t;

    // Scan results.
    typedef struct packed {
        logic                  idle_found;
        logic [IDX_W-1:0]      idle_idx;
        logic                  any_found;
        logic [IDX_W-1:0]      any_idx;
        logic                  min_found;
        logic [IDX_W-1:0]      min_idx;
        logic [COUNT_BITS-1:0] min_cnt;
    } scan_res_t;

endpackage

FILE: src/rra_table.sv
module rra_table (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [rra_pkg::IDX_W-1:0] rd_addr,
    input  rra_pkg::tbl_wr_t wr,
    output rra_pkg::entry_t  rd_entry
);
    import rra_pkg::*;

    localparam int WORD_W = WIDTH_W + 1 + COUNT_BITS;

    logic [WORD_W-1:0]   mem [NUM_REGS];
    logic [WORD_W-1:0]   rd_word_reg;
    logic [NUM_REGS-1:0] def_valid_reg;
    logic [NUM_REGS-1:0] cnt_ok_reg;
    logic                rd_def_reg;
    logic                rd_cnt_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= {wr.width, wr.res, wr.count};
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // Count reads as zero until the entry's count is first written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_valid_reg <= '0;
            cnt_ok_reg    <= '0;
            rd_def_reg    <= 1'b0;
            rd_cnt_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                cnt_ok_reg[wr.addr] <= 1'b1;
                if (wr.define)
                begin
                    def_valid_reg[wr.addr] <= 1'b1;
                end
            end
            if (rd_en)
            begin
                rd_def_reg    <= def_valid_reg[rd_addr];
                rd_cnt_ok_reg <= cnt_ok_reg[rd_addr];
            end
        end
    end

    always_comb
    begin
        rd_entry.valid = rd_def_reg;
        rd_entry.width = rd_word_reg[WORD_W-1 -: WIDTH_W];
        rd_entry.res   = rd_word_reg[COUNT_BITS];
        rd_entry.count = rd_cnt_ok_reg ? rd_word_reg[COUNT_BITS-1:0] : '0;
    end

endmodule

FILE: src/rra_scan.sv
module rra_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  rra_pkg::scan_ctl_t ctl,
    input  rra_pkg::entry_t    entry,
    output rra_pkg::scan_res_t res
);
    import rra_pkg::*;

    scan_res_t res_reg;
    scan_res_t res_next;

    always_comb
    begin
        res_next = res_reg;
        if (ctl.clear)
        begin
            res_next.idle_found = 1'b0;
            res_next.any_found  = 1'b0;
            res_next.min_found  = 1'b0;
        end
        else if (ctl.sample && entry.valid && entry.width == ctl.key)
        begin
            if (!res_reg.any_found)
            begin
                res_next.any_found = 1'b1;
                res_next.any_idx   = ctl.idx;
            end
            if (!res_reg.idle_found && entry.count == '0 && entry.res)
            begin
                res_next.idle_found = 1'b1;
                res_next.idle_idx   = ctl.idx;
            end
            // strict compare keeps the lowest index on ties
            if (!res_reg.min_found || entry.count < res_reg.min_cnt)
            begin
                res_next.min_found = 1'b1;
                res_next.min_idx   = ctl.idx;
                res_next.min_cnt   = entry.count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: src/refcounted_register_allocator.sv
// Reference-counted register allocator. A table of NUM_REGS entries (width,
// reservable flag, saturating use count) sits in a synchronous memory with
// one read and one write port; each op reads one entry and may update and
// write it back. Direct ops (define, reserve by index, free, query) with an
// index in range go from the accept through a fetch state and an apply state,
// which loads the result into the output register. Ops that search by width
// (reserve, reserve by width, take by width) first walk the memory one entry
// per cycle in a scan state, then pick an entry before the same fetch and
// apply states. A new word is taken only once the previous one has been
// placed in the output register; a result waiting there does not block the
// next word from being accepted, but that word holds in its last step until
// the output register frees up. Use counts read as zero after reset with no
// clearing pass; arch_width resets to 64 and is written directly.
`include "refcounted_register_allocator_macros.svh"

module refcounted_register_allocator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [2:0] op,
    input  logic [3:0] reg_index,
    input  logic [6:0] width_bits,
    input  logic       can_reserve,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [3:0] chosen_index,
    output logic [1:0] status,
    output logic       busy_res,
    output logic [7:0] use_count_out
);
    import rra_pkg::*;

    state_t                state_reg, state_next;
    logic [WIDTH_W-1:0]    arch_width_reg;
    op_t                   op_reg;
    logic [WIDTH_W-1:0]    w_reg;
    logic                  cr_reg;
    logic [WIDTH_W-1:0]    key_reg;
    logic [IDX_W-1:0]      tgt_reg, tgt_next;
    logic [SCAN_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                  scan_pend_reg;
    logic [IDX_W-1:0]      scan_idx_reg;

    logic                  res_valid_reg;
    logic [OUT_IDX_W-1:0]  idx_out_reg, idx_out_next;
    status_t               stat_out_reg, stat_out_next;
    logic                  busy_out_reg, busy_out_next;
    logic [OUT_CNT_W-1:0]  cnt_out_reg, cnt_out_next;

    logic                  capture;
    logic                  load_out;
    logic                  out_free;
    logic                  in_range;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    tbl_wr_t               tbl_wr;
    entry_t                rd_entry;
    scan_ctl_t             scl;
    scan_res_t             sres;

    logic                  do_bump;
    logic                  do_wr;
    logic                  fail;
    logic [COUNT_BITS-1:0] new_cnt;
    status_t               new_stat;

    rra_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr       (tbl_wr),
        .rd_entry (rd_entry)
    );

    rra_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scl),
        .entry (rd_entry),
        .res   (sres)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign out_free   = !res_valid_reg || res_ready;
    assign in_range   = (32'(reg_index) < 32'(NUM_REGS));

    always_comb
    begin
        state_next    = state_reg;
        tgt_next      = tgt_reg;
        scan_cnt_next = scan_cnt_reg;
        capture       = 1'b0;
        load_out      = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = tgt_reg;
        scl.clear     = 1'b0;
        scl.sample    = scan_pend_reg;
        scl.idx       = scan_idx_reg;
        scl.key       = key_reg;

        do_bump  = 1'b0;
        do_wr    = 1'b0;
        fail     = 1'b0;
        new_cnt  = rd_entry.count;
        new_stat = STAT_OK;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    capture       = 1'b1;
                    scl.clear     = 1'b1;
                    scan_cnt_next = '0;
                    tgt_next      = IDX_W'(reg_index);
                    if (op_t'(op) inside {OP_RESERVE, OP_RESERVE_WIDTH, OP_TAKE_WIDTH})
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (op_t'(op) inside {OP_DEFINE, OP_RESERVE_IDX, OP_FREE,
                                               OP_QUERY} && in_range)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_FAIL;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg != SCAN_W'(NUM_REGS))
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = ST_FAIL;
                case (op_reg)
                    OP_RESERVE:
                    begin
                        if (sres.idle_found)
                        begin
                            tgt_next   = sres.idle_idx;
                            state_next = ST_FETCH;
                        end
                        else if (sres.min_found)
                        begin
                            tgt_next   = sres.min_idx;
                            state_next = ST_FETCH;
                        end
                    end
                    OP_RESERVE_WIDTH:
                    begin
                        if (sres.idle_found)
                        begin
                            tgt_next   = sres.idle_idx;
                            state_next = ST_FETCH;
                        end
                    end
                    OP_TAKE_WIDTH:
                    begin
                        if (sres.any_found)
                        begin
                            tgt_next   = sres.any_idx;
                            state_next = ST_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FAIL;
                    end
                endcase
            end
            ST_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = tgt_reg;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                case (op_reg)
                    OP_DEFINE:
                    begin
                        do_wr = 1'b1;
                    end
                    OP_RESERVE_IDX:
                    begin
                        if (!rd_entry.valid || !rd_entry.res)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            do_bump = 1'b1;
                        end
                    end
                    OP_RESERVE, OP_RESERVE_WIDTH, OP_TAKE_WIDTH:
                    begin
                        do_bump = 1'b1;
                    end
                    OP_FREE:
                    begin
                        if (rd_entry.count == '0)
                        begin
                            new_stat = STAT_FREE_ZERO;
                        end
                        else
                        begin
                            new_cnt = rd_entry.count - 1'b1;
                            do_wr   = 1'b1;
                        end
                    end
                    OP_QUERY:
                    begin
                        new_stat = STAT_OK;
                    end
                    default:
                    begin
                        fail = 1'b1;
                    end
                endcase
                if (do_bump)
                begin
                    // hold the count at its maximum and flag it
                    if (rd_entry.count == CNT_MAX)
                    begin
                        new_stat = STAT_SAT;
                    end
                    else
                    begin
                        new_cnt = rd_entry.count + 1'b1;
                        do_wr   = 1'b1;
                    end
                end
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FAIL:
            begin
                fail = 1'b1;
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        tbl_wr.en     = do_wr && !fail && load_out;
        tbl_wr.define = (op_reg == OP_DEFINE);
        tbl_wr.addr   = tgt_reg;
        tbl_wr.width  = (op_reg == OP_DEFINE) ? w_reg : rd_entry.width;
        tbl_wr.res    = (op_reg == OP_DEFINE) ? cr_reg : rd_entry.res;
        tbl_wr.count  = new_cnt;

        if (fail)
        begin
            idx_out_next  = '0;
            stat_out_next = STAT_NONE;
            busy_out_next = 1'b0;
            cnt_out_next  = '0;
        end
        else
        begin
            idx_out_next  = OUT_IDX_W'(tgt_reg);
            stat_out_next = new_stat;
            busy_out_next = (new_cnt != '0);
            cnt_out_next  = OUT_CNT_W'(new_cnt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            arch_width_reg <= ARCH_WIDTH_RST;
            scan_cnt_reg   <= '0;
            scan_pend_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            scan_pend_reg <= (state_reg == ST_SCAN) && (scan_cnt_reg != SCAN_W'(NUM_REGS));
            if (cfg_wr_en)
            begin
                arch_width_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg      <= tgt_next;
        scan_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        if (capture)
        begin
            op_reg  <= op_t'(op);
            w_reg   <= width_bits;
            cr_reg  <= can_reserve;
            key_reg <= (op_t'(op) == OP_RESERVE) ? arch_width_reg : width_bits;
        end
        if (load_out)
        begin
            idx_out_reg  <= idx_out_next;
            stat_out_reg <= stat_out_next;
            busy_out_reg <= busy_out_next;
            cnt_out_reg  <= cnt_out_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign chosen_index  = idx_out_reg;
    assign status        = stat_out_reg;
    assign busy_res      = busy_out_reg;
    assign use_count_out = cnt_out_reg;

    `RRA_ASSERT_NOW(a_wr_only_apply, tbl_wr.en, state_reg == ST_APPLY && load_out, "table write outside apply")
    `RRA_ASSERT_NEXT(a_accept_leaves_idle, item_valid && item_ready, state_reg != ST_IDLE, "accepted word did not start")
    `RRA_ASSERT_NOW(a_none_zero_fields, res_valid && status == STAT_NONE, chosen_index == '0 && !busy_res && use_count_out == '0, "failed result carries data")
    `RRA_ASSERT_NOW(a_sat_at_max, res_valid && status == STAT_SAT, use_count_out == OUT_CNT_W'(CNT_MAX) && busy_res, "saturated result below maximum")
    `RRA_ASSERT_NOW(a_load_needs_slot, load_out, !res_valid_reg || res_ready, "result overwrote a pending word")

endmodule
